### rtl/asma_pkg.sv
// Shared widths and constants for the smoothed moving average core.
package asma_pkg;

  localparam int unsigned SampleW    = 12;
  localparam int unsigned RefW       = 16;
  localparam int unsigned MvW        = 16;
  // Window length is a power of two: the mean is a plain shift of the sum.
  localparam int unsigned WinLenLog2 = 4;
  localparam int unsigned WindowLen  = 1 << WinLenLog2;
  localparam int unsigned SumW       = SampleW + WinLenLog2;
  localparam int unsigned ProdW      = SampleW + RefW;
  localparam int unsigned RemW       = SampleW + 1;

  localparam logic [SampleW-1:0] FullScale = {SampleW{1'b1}};
  localparam logic [RefW-1:0]    RefReset  = RefW'(3300);

  typedef logic [SampleW-1:0]    sample_t;
  typedef logic [SumW-1:0]       sum_t;
  typedef logic [ProdW-1:0]      prod_t;
  typedef logic [MvW-1:0]        mv_t;
  typedef logic [WinLenLog2-1:0] win_idx_t;

endpackage

### rtl/adc_smoothed_moving_average_core.sv
// Smoothed moving average of converter samples with millivolt scaling.
// A result is valid on out_valid_o once its sample has passed the registered stages a, b, c and d.
// Throughput: one sample per cycle while in_ready_o is high; the smoothing, window and running sum update together.
// Scaling runs in three further stages: multiply, reciprocal estimate, one-step correction.
// Reset: window, sum, smoothed value and index clear to zero; reference returns to 3300 mV.
// Pipeline stages advance independently, so bubbles are squeezed out during output stalls.
module adc_smoothed_moving_average_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  ref_millivolts_we_i,
  input  logic [asma_pkg::RefW-1:0]    ref_millivolts_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [asma_pkg::SampleW-1:0] sample_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [asma_pkg::SampleW-1:0] average_code_o,
  output logic [asma_pkg::MvW-1:0]     millivolts_o
);
  import asma_pkg::*;

  // Configuration register
  logic [RefW-1:0] ref_q;

  // Filter state
  sample_t  smooth_q, smooth_d;
  sample_t  win_q [WindowLen];
  win_idx_t wr_idx_q;
  sum_t     sum_q, sum_d;

  // Pipeline stages
  logic    a_v_q, b_v_q, c_v_q, d_v_q;
  sample_t a_mean_q, b_mean_q, c_mean_q, d_mean_q;
  prod_t   b_prod_q, c_prod_q;
  mv_t     c_qest_q, d_mv_q;

  logic adv_a, adv_b, adv_c, adv_d;
  logic accept;

  // Reciprocal estimate and correction signals
  logic [ProdW:0] recip_sum;
  logic [ProdW:0] rem_full;
  logic [RemW-1:0] rem;
  mv_t mv_d;

  // Each stage moves when its successor has room.
  assign adv_d      = !d_v_q || out_ready_i;
  assign adv_c      = !c_v_q || adv_d;
  assign adv_b      = !b_v_q || adv_c;
  assign adv_a      = !a_v_q || adv_b;
  assign in_ready_o = adv_a;
  assign accept     = in_valid_i && in_ready_o;

  // Smooth against the previous value, then swap the oldest window entry in the sum.
  always_comb begin
    smooth_d = SampleW'(({1'b0, sample_i} + {1'b0, smooth_q}) >> 1);
    sum_d    = sum_q + SumW'(smooth_d) - SumW'(win_q[wr_idx_q]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= RefReset;
    end else if (ref_millivolts_we_i) begin
      ref_q <= ref_millivolts_i;
    end
  end

  // Update the window on every taken item; the index wraps at the window length.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= '0;
      sum_q    <= '0;
      wr_idx_q <= '0;
      for (int i = 0; i < WindowLen; i++) begin
        win_q[i] <= '0;
      end
    end else if (accept) begin
      smooth_q        <= smooth_d;
      sum_q           <= sum_d;
      win_q[wr_idx_q] <= smooth_d;
      wr_idx_q        <= wr_idx_q + 1'b1;
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else begin
      if (adv_a) a_v_q <= accept;
      if (adv_b) b_v_q <= a_v_q;
      if (adv_c) c_v_q <= b_v_q;
      if (adv_d) d_v_q <= c_v_q;
    end
  end

  // x / 4095 for x below 2^28: x * (1 + 2^-12 + 2^-24) / 4096 never overshoots
  // and falls short by at most one.
  always_comb begin
    recip_sum = {1'b0, b_prod_q} + (ProdW+1)'(b_prod_q >> SampleW)
              + (ProdW+1)'(b_prod_q >> (2 * SampleW));
    rem_full  = {1'b0, c_prod_q} - ((ProdW+1)'(c_qest_q) << SampleW)
              + (ProdW+1)'(c_qest_q);
    rem       = rem_full[RemW-1:0];
    mv_d      = (rem >= RemW'(FullScale)) ? c_qest_q + 1'b1 : c_qest_q;
  end

  // Stage payloads hold while stalled.
  always_ff @(posedge clk_i) begin
    if (adv_a && accept) begin
      a_mean_q <= sum_d[SumW-1:WinLenLog2];
    end
    if (adv_b) begin
      b_mean_q <= a_mean_q;
      b_prod_q <= ProdW'(a_mean_q) * ProdW'(ref_q);
    end
    if (adv_c) begin
      c_mean_q <= b_mean_q;
      c_prod_q <= b_prod_q;
      c_qest_q <= recip_sum[SampleW +: MvW];
    end
    if (adv_d) begin
      d_mean_q <= c_mean_q;
      d_mv_q   <= mv_d;
    end
  end

  assign out_valid_o    = d_v_q;
  assign average_code_o = d_mean_q;
  assign millivolts_o   = d_mv_q;

  // The index steps by one on each taken item and holds otherwise.
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> wr_idx_q == win_idx_t'($past(wr_idx_q) + 1'b1))
    else $error("write index did not advance on a taken item");

  a_idx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(wr_idx_q))
    else $error("write index moved without a taken item");

  // Input backpressure only when every stage is full.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (a_v_q && b_v_q && c_v_q && d_v_q))
    else $error("input stalled with room in the pipeline");

  // The reciprocal estimate is off by at most one.
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_v_q |-> rem_full < (ProdW+1)'(2 * FullScale))
    else $error("division remainder out of range");

  // Scaled output never exceeds the reference.
  a_mv_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> millivolts_o <= ref_q)
    else $error("millivolts above reference");

endmodule

### bench/adc_smoothed_moving_average_core_test.sv
// Self-checking testbench for the smoothed moving average core.
`timescale 1ns / 1ps

module adc_smoothed_moving_average_core_test;
  import asma_pkg::*;

  // Give up on the run after this many cycles; a correct run needs a small fraction.
  localparam int unsigned CycleLimit  = 400000;
  // Settle time after the last expected average: covers the four-stage pipeline.
  localparam int unsigned SettleCycles = 10;
  // Length of the long output hold-off that fills the pipeline.
  localparam int unsigned HoldCycles  = 80;

  typedef struct packed {
    sample_t average_code;
    mv_t     millivolts;
  } average_t;

  // Stall modes of the output side.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_e;

  logic              clk_i;
  logic              rst_ni;
  logic              ref_millivolts_we_i;
  logic [RefW-1:0]   ref_millivolts_i;
  logic              in_valid_i;
  logic              in_ready_o;
  sample_t           sample_i;
  logic              out_valid_o;
  logic              out_ready_i;
  sample_t           average_code_o;
  mv_t               millivolts_o;

  // Shadow copy of the filter state, advanced once per accepted sample.
  sample_t           smoothed_shadow;
  sample_t           window_shadow [WindowLen];
  win_idx_t          write_idx_shadow;
  logic [RefW-1:0]   ref_mv_shadow;

  // Averages predicted but not yet seen on the output, oldest first.
  average_t          expected_averages [$];

  int unsigned       cycle_count;
  int unsigned       samples_sent;
  int unsigned       averages_checked;
  int unsigned       ref_writes;
  int unsigned       mismatch_count;
  bit                hold_request;
  bit                square_phase;

  adc_smoothed_moving_average_core u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ref_millivolts_we_i (ref_millivolts_we_i),
    .ref_millivolts_i    (ref_millivolts_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .sample_i            (sample_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .average_code_o      (average_code_o),
    .millivolts_o        (millivolts_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("** adc_smoothed_moving_average_core: FAILED **");
      $finish;
    end
  end

  // Smooth the sample, store it, advance the index and form the scaled mean.
  function automatic average_t smooth_and_average(input sample_t raw);
    int unsigned window_sum;
    int unsigned k;
    average_t    avg;
    // Halve the 13-bit sum: the result always fits back into 12 bits.
    smoothed_shadow = sample_t'(({1'b0, raw} + {1'b0, smoothed_shadow}) >> 1);
    window_shadow[write_idx_shadow] = smoothed_shadow;
    // The index is exactly as wide as the window, so it wraps by itself.
    write_idx_shadow = write_idx_shadow + 1'b1;
    window_sum = 0;
    for (k = 0; k < WindowLen; k++) begin
      window_sum += window_shadow[k];
    end
    avg.average_code = sample_t'(window_sum / WindowLen);
    avg.millivolts   = mv_t'((32'(avg.average_code) * 32'(ref_mv_shadow))
                             / 32'(FullScale));
    return avg;
  endfunction

  // Compare every accepted average against the oldest prediction.
  always @(posedge clk_i) begin
    average_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_averages.size() == 0) begin
        $error("unexpected average: average_code %0d, millivolts %0d",
               average_code_o, millivolts_o);
        mismatch_count++;
      end else begin
        want = expected_averages.pop_front();
        averages_checked++;
        if (average_code_o !== want.average_code) begin
          $error("average_code mismatch: expected %0d, actual %0d",
                 want.average_code, average_code_o);
          mismatch_count++;
        end
        if (millivolts_o !== want.millivolts) begin
          $error("millivolts mismatch: expected %0d, actual %0d",
                 want.millivolts, millivolts_o);
          mismatch_count++;
        end
      end
    end
  end

  // Output side: switch between stall modes now and then; honor a long hold request.
  initial begin
    rx_mode_e    mode;
    logic [7:0]  ready_mask;
    int unsigned mode_left;
    out_ready_i = 1'b0;
    mode        = RX_ALWAYS;
    ready_mask  = 8'hFF;
    mode_left   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        // Hold off long enough for the pipeline to fill and block the input.
        out_ready_i <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        out_ready_i  <= 1'b1;
        hold_request = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(32, 256);
          case ($urandom_range(0, 2))
            0:       mode = RX_ALWAYS;
            1:       mode = RX_RANDOM;
            default: mode = RX_PATTERN;
          endcase
          ready_mask = 8'($urandom_range(1, 255));
        end
        mode_left--;
        case (mode)
          RX_ALWAYS:  out_ready_i <= 1'b1;
          RX_RANDOM:  out_ready_i <= ($urandom_range(0, 3) != 0);
          RX_PATTERN: begin
            out_ready_i <= ready_mask[0];
            ready_mask  = {ready_mask[0], ready_mask[7:1]};
          end
          default:    out_ready_i <= 1'b1;
        endcase
      end
    end
  end

  // Offer one sample from a falling edge; return at the falling edge after it is taken.
  // Valid stays high on return so back-to-back items need no extra edge.
  task automatic send_sample(input sample_t raw);
    in_valid_i <= 1'b1;
    sample_i   <= raw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_averages.push_back(smooth_and_average(raw));
    samples_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid for a number of cycles.
  task automatic sender_gap(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Stop sending until every predicted average has come out, then let the pipeline settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_averages.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Change the reference only with the block idle.
  task automatic write_reference(input logic [RefW-1:0] ref_mv);
    wait_drained();
    ref_millivolts_we_i <= 1'b1;
    ref_millivolts_i    <= ref_mv;
    @(negedge clk_i);
    ref_millivolts_we_i <= 1'b0;
    ref_mv_shadow = ref_mv;
    ref_writes++;
  endtask

  // Mix of full-range values, both rails, near-rail values and a square wave.
  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return FullScale;
      2:       return sample_t'($urandom_range(0, 15));
      3:       return sample_t'($urandom_range(4080, 4095));
      4: begin
        square_phase = ~square_phase;
        return square_phase ? FullScale : '0;
      end
      default: return sample_t'($urandom_range(0, 4095));
    endcase
  endfunction

  // Ramp the window up from its cleared state, run past the index wrap, then hit
  // the rails and alternating bit patterns.
  task automatic test_window_ramp_and_wrap();
    repeat (18) send_sample(FullScale);
    send_sample('0);
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_sample(12'h001);
    send_sample(12'h800);
    wait_drained();
  endtask

  // Scale at the reference extremes and a few odd values.
  task automatic test_reference_extremes();
    write_reference('0);
    send_sample(FullScale);
    send_sample(12'h123);
    write_reference('1);
    send_sample(FullScale);
    send_sample(FullScale);
    send_sample('0);
    write_reference(RefW'(1));
    send_sample(FullScale);
    write_reference(RefW'(4095));
    send_sample(12'h7FF);
    write_reference(RefReset);
    send_sample(12'hFFE);
    wait_drained();
  endtask

  // Hold the output off while samples keep coming, so the input must stall.
  task automatic test_backpressure_fill();
    hold_request = 1'b1;
    repeat (40) send_sample(random_sample());
    // Pause until everything has come out, then resume back to back.
    wait_drained();
    repeat (8) send_sample(random_sample());
    wait_drained();
  endtask

  // Random samples in bursts with gaps; change the reference between segments.
  task automatic test_random_bursts();
    int unsigned burst_len;
    int unsigned segment;
    int unsigned sent_in_segment;
    for (segment = 0; segment < 6; segment++) begin
      case ($urandom_range(0, 4))
        0:       write_reference('0);
        1:       write_reference('1);
        2:       write_reference(RefReset);
        default: write_reference(RefW'($urandom_range(0, 65535)));
      endcase
      sent_in_segment = 0;
      while (sent_in_segment < 125) begin
        burst_len = $urandom_range(1, 24);
        repeat (burst_len) send_sample(random_sample());
        sent_in_segment += burst_len;
        // Leave some bursts joined with no idle cycle between them.
        if ($urandom_range(0, 3) != 0) begin
          sender_gap($urandom_range(1, 6));
        end
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_ni              = 1'b0;
    in_valid_i          = 1'b0;
    sample_i            = '0;
    ref_millivolts_we_i = 1'b0;
    ref_millivolts_i    = '0;
    cycle_count         = 0;
    samples_sent        = 0;
    averages_checked    = 0;
    ref_writes          = 0;
    mismatch_count      = 0;
    hold_request        = 1'b0;
    square_phase        = 1'b0;
    smoothed_shadow     = '0;
    write_idx_shadow    = '0;
    ref_mv_shadow       = RefReset;
    foreach (window_shadow[i]) window_shadow[i] = '0;

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_window_ramp_and_wrap();
    test_reference_extremes();
    test_backpressure_fill();
    test_random_bursts();

    $display("Sent %0d samples and checked %0d averages across %0d reference settings,",
             samples_sent, averages_checked, ref_writes + 1);
    $display("with window wrap, output hold-off and bursty input; %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("** adc_smoothed_moving_average_core: PASSED **");
    end else begin
      $display("** adc_smoothed_moving_average_core: FAILED **");
    end
    $finish;
  end

endmodule
